// ----- rtl/lphm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lphm_pkg: shared types and constants of the linear probe hash map
// beat layouts, memory word layout, opcodes, status codes and slot marks
// ----------------------------------------------------------------------------
package lphm_pkg;

    // table depth, a power of two
    localparam int TABLE_DEPTH = 128;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // opcodes
    localparam logic [2:0] OP_LOOKUP = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_SCAN   = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // slot marks
    localparam logic [1:0] MARK_EMPTY   = 2'd0;
    localparam logic [1:0] MARK_USED    = 2'd1;
    localparam logic [1:0] MARK_DELETED = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] key;
        logic [31:0] value;
        logic [7:0]  position;
    } lphm_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_key;
        logic [31:0] found_value;
        logic [6:0]  slot;
        logic [7:0]  entry_total;
    } lphm_rsp_t;

    typedef struct packed {
        logic [1:0]  mark;
        logic [31:0] key;
        logic [31:0] value;
    } lphm_entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_FINISH
    } lphm_state_t;

endpackage
`default_nettype wire

// ----- rtl/linear_probe_hash_map.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_map: open addressing hash map, 32-bit keys and values
// one table memory probed one slot per cycle, one result beat per request
// ----------------------------------------------------------------------------
// The block holds up to 128 key/value pairs in one single-port-read,
// single-port-write table memory with a registered read port. A request
// beat is taken when the block is idle; it then walks the table one slot per
// cycle. A lookup, insert or remove probes the slots from the home slot on
// (one slot with no collisions, at most 128), and a scan examines the slots
// from the start position up to the first used slot or the last slot. Clear
// all does no walk: slot states live in a row of valid flags next to the
// memory, and clear drops all of them at once, so no clearing pass is
// needed after reset or clear. The probe rate is set by the read-decide-read
// loop through the table memory. A finished result sits in an output
// register, so the next request is taken while it waits.
// ----------------------------------------------------------------------------
module linear_probe_hash_map (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire lphm_pkg::lphm_req_t req,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output lphm_pkg::lphm_rsp_t     rsp
);

    // table memory and its registered read port
    lphm_pkg::lphm_entry_t mem [lphm_pkg::TABLE_DEPTH];
    lphm_pkg::lphm_entry_t rd_data_reg;
    logic [lphm_pkg::ADDR_W-1:0] mem_rd_addr;
    logic                        mem_we;
    logic [lphm_pkg::ADDR_W-1:0] mem_wa;
    lphm_pkg::lphm_entry_t       mem_wd;

    // control state
    lphm_pkg::lphm_state_t state_reg, state_next;
    logic [lphm_pkg::TABLE_DEPTH-1:0] slot_valid_reg, slot_valid_next;
    logic [lphm_pkg::CNT_W-1:0]       live_reg, live_next;
    logic                             rsp_valid_reg, rsp_valid_next;

    // per-request working registers
    lphm_pkg::lphm_req_t         cmd_reg, cmd_next;
    logic [lphm_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [lphm_pkg::CNT_W-1:0]  probe_cnt_reg, probe_cnt_next;
    logic                        hit_reg, hit_next;
    logic                        at_empty_reg, at_empty_next;
    logic                        hole_vld_reg, hole_vld_next;
    logic [lphm_pkg::ADDR_W-1:0] hole_reg, hole_next;
    logic [lphm_pkg::ADDR_W-1:0] where_reg, where_next;
    logic [31:0]                 hit_key_reg, hit_key_next;
    logic [31:0]                 hit_val_reg, hit_val_next;
    lphm_pkg::lphm_rsp_t         rsp_reg, rsp_next;

    // decode helpers
    logic                        req_take;
    logic                        rsp_free;
    logic [31:0]                 key_mag;
    logic [lphm_pkg::ADDR_W-1:0] home_slot;
    logic                        scan_in_range;
    logic [1:0]                  cur_mark;
    logic                        is_scan;
    logic                        last_probe;
    logic [lphm_pkg::ADDR_W-1:0] next_addr;
    logic                        probe_hit;
    logic                        probe_empty;
    logic                        probe_end;
    logic [lphm_pkg::ADDR_W-1:0] ins_addr;

    assign req_stall = (state_reg != lphm_pkg::S_IDLE);
    assign req_take  = req_valid && (state_reg == lphm_pkg::S_IDLE);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // home slot: magnitude of the key as a signed number, low address bits
    assign key_mag       = req.key[31] ? (32'd0 - req.key) : req.key;
    assign home_slot     = key_mag[lphm_pkg::ADDR_W-1:0];
    assign scan_in_range = int'(req.position) < lphm_pkg::TABLE_DEPTH;

    // probe decision on the slot whose data just came back
    assign cur_mark    = slot_valid_reg[addr_reg] ? rd_data_reg.mark : lphm_pkg::MARK_EMPTY;
    assign is_scan     = (cmd_reg.op == lphm_pkg::OP_SCAN);
    assign last_probe  = (probe_cnt_reg == lphm_pkg::CNT_W'(lphm_pkg::TABLE_DEPTH - 1));
    assign next_addr   = (addr_reg == lphm_pkg::ADDR_W'(lphm_pkg::TABLE_DEPTH - 1))
                         ? '0 : addr_reg + 1'b1;
    assign probe_empty = !is_scan && (cur_mark == lphm_pkg::MARK_EMPTY);

    always_comb
    begin
        if (is_scan)
        begin
            probe_hit = (cur_mark == lphm_pkg::MARK_USED);
            probe_end = probe_hit
                        || (addr_reg == lphm_pkg::ADDR_W'(lphm_pkg::TABLE_DEPTH - 1));
        end
        else
        begin
            probe_hit = (cur_mark == lphm_pkg::MARK_USED) && (rd_data_reg.key == cmd_reg.key);
            probe_end = probe_hit || probe_empty || last_probe;
        end
    end

    // a new key goes to the first deleted slot seen, else the empty slot
    assign ins_addr = hole_vld_reg ? hole_reg : where_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lphm_pkg::S_IDLE:
            begin
                if (req_take)
                begin
                    if ((req.op == lphm_pkg::OP_LOOKUP) || (req.op == lphm_pkg::OP_INSERT)
                        || (req.op == lphm_pkg::OP_REMOVE))
                        state_next = lphm_pkg::S_PROBE;
                    else if ((req.op == lphm_pkg::OP_SCAN) && scan_in_range)
                        state_next = lphm_pkg::S_PROBE;
                    else
                        state_next = lphm_pkg::S_FINISH;
                end
            end
            lphm_pkg::S_PROBE:
            begin
                if (probe_end)
                    state_next = lphm_pkg::S_FINISH;
            end
            lphm_pkg::S_FINISH:
            begin
                if (rsp_free)
                    state_next = lphm_pkg::S_IDLE;
            end
            default:
            begin
                state_next = lphm_pkg::S_IDLE;
            end
        endcase
    end

    // datapath, memory port and result
    always_comb
    begin
        cmd_next        = cmd_reg;
        addr_next       = addr_reg;
        probe_cnt_next  = probe_cnt_reg;
        hit_next        = hit_reg;
        at_empty_next   = at_empty_reg;
        hole_vld_next   = hole_vld_reg;
        hole_next       = hole_reg;
        where_next      = where_reg;
        hit_key_next    = hit_key_reg;
        hit_val_next    = hit_val_reg;
        slot_valid_next = slot_valid_reg;
        live_next       = live_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        mem_rd_addr     = addr_reg;
        mem_we          = 1'b0;
        mem_wa          = where_reg;
        mem_wd          = rd_data_reg;

        case (state_reg)
            lphm_pkg::S_IDLE:
            begin
                if (req_take)
                begin
                    cmd_next       = req;
                    probe_cnt_next = '0;
                    hit_next       = 1'b0;
                    at_empty_next  = 1'b0;
                    hole_vld_next  = 1'b0;
                    where_next     = '0;
                    if (req.op == lphm_pkg::OP_SCAN)
                        addr_next = lphm_pkg::ADDR_W'(req.position);
                    else
                        addr_next = home_slot;
                    mem_rd_addr = addr_next;
                end
            end
            lphm_pkg::S_PROBE:
            begin
                // remember the first deleted slot on the walk
                if (!is_scan && (cur_mark == lphm_pkg::MARK_DELETED) && !hole_vld_reg)
                begin
                    hole_vld_next = 1'b1;
                    hole_next     = addr_reg;
                end
                if (probe_end)
                begin
                    hit_next      = probe_hit;
                    at_empty_next = probe_empty;
                    hit_key_next  = rd_data_reg.key;
                    hit_val_next  = rd_data_reg.value;
                    // full walk without a hit wraps back to the home slot
                    where_next    = (probe_hit || probe_empty || is_scan) ? addr_reg : next_addr;
                end
                else
                begin
                    addr_next      = next_addr;
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                    mem_rd_addr    = next_addr;
                end
            end
            lphm_pkg::S_FINISH:
            begin
                if (rsp_free)
                begin
                    rsp_next.status      = lphm_pkg::ST_MISS;
                    rsp_next.found_key   = cmd_reg.key;
                    rsp_next.found_value = '0;
                    rsp_next.slot        = '0;
                    case (cmd_reg.op)
                        lphm_pkg::OP_LOOKUP:
                        begin
                            rsp_next.slot = where_reg;
                            if (hit_reg)
                            begin
                                rsp_next.status      = lphm_pkg::ST_OK;
                                rsp_next.found_value = hit_val_reg;
                            end
                        end
                        lphm_pkg::OP_INSERT:
                        begin
                            mem_wd.mark  = lphm_pkg::MARK_USED;
                            mem_wd.key   = cmd_reg.key;
                            mem_wd.value = cmd_reg.value;
                            if (hit_reg)
                            begin
                                mem_we          = 1'b1;
                                mem_wa          = where_reg;
                                rsp_next.status = lphm_pkg::ST_OK;
                                rsp_next.slot   = where_reg;
                            end
                            else if (hole_vld_reg || at_empty_reg)
                            begin
                                mem_we                  = 1'b1;
                                mem_wa                  = ins_addr;
                                slot_valid_next[ins_addr] = 1'b1;
                                live_next               = live_reg + 1'b1;
                                rsp_next.status         = lphm_pkg::ST_OK;
                                rsp_next.slot           = ins_addr;
                            end
                            else
                            begin
                                rsp_next.status = lphm_pkg::ST_FULL;
                                rsp_next.slot   = where_reg;
                            end
                        end
                        lphm_pkg::OP_REMOVE:
                        begin
                            rsp_next.slot = where_reg;
                            if (hit_reg)
                            begin
                                mem_we          = 1'b1;
                                mem_wa          = where_reg;
                                mem_wd.mark     = lphm_pkg::MARK_DELETED;
                                mem_wd.key      = hit_key_reg;
                                mem_wd.value    = hit_val_reg;
                                live_next       = live_reg - 1'b1;
                                rsp_next.status = lphm_pkg::ST_OK;
                            end
                        end
                        lphm_pkg::OP_CLEAR:
                        begin
                            slot_valid_next = '0;
                            live_next       = '0;
                            rsp_next.status = lphm_pkg::ST_OK;
                        end
                        lphm_pkg::OP_SCAN:
                        begin
                            if (hit_reg)
                            begin
                                rsp_next.status      = lphm_pkg::ST_OK;
                                rsp_next.found_key   = hit_key_reg;
                                rsp_next.found_value = hit_val_reg;
                                rsp_next.slot        = where_reg;
                            end
                        end
                        default:
                        begin
                            rsp_next.status = lphm_pkg::ST_MISS;
                        end
                    endcase
                    rsp_next.entry_total = live_next;
                    rsp_valid_next       = 1'b1;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // table memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[mem_rd_addr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lphm_pkg::S_IDLE;
            slot_valid_reg <= '0;
            live_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_valid_reg <= slot_valid_next;
            live_reg       <= live_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        addr_reg      <= addr_next;
        probe_cnt_reg <= probe_cnt_next;
        hit_reg       <= hit_next;
        at_empty_reg  <= at_empty_next;
        hole_vld_reg  <= hole_vld_next;
        hole_reg      <= hole_next;
        where_reg     <= where_next;
        hit_key_reg   <= hit_key_next;
        hit_val_reg   <= hit_val_next;
        rsp_reg       <= rsp_next;
    end

endmodule
`default_nettype wire

// ----- rtl/lphm_check.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lphm_check: port-level checks of the linear probe hash map
// watches the request and result channels and the reported entry count
// ----------------------------------------------------------------------------
module lphm_check (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                req_valid,
    input wire logic                req_stall,
    input wire lphm_pkg::lphm_req_t req,
    input wire logic                rsp_valid,
    input wire logic                rsp_stall,
    input wire lphm_pkg::lphm_rsp_t rsp
);

    // one request in flight: a taken beat stalls the next cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request taken while previous request still in work");

    // a stalled result beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("result beat changed while stalled");

    // entry count never exceeds the table and status codes stay in range
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((int'(rsp.entry_total) <= lphm_pkg::TABLE_DEPTH)
                       && ((rsp.status == lphm_pkg::ST_OK)
                           || (rsp.status == lphm_pkg::ST_MISS)
                           || (rsp.status == lphm_pkg::ST_FULL))))
        else $error("result beat out of range");

    // full is only reported when every slot holds a live entry
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == lphm_pkg::ST_FULL))
            |-> (int'(rsp.entry_total) == lphm_pkg::TABLE_DEPTH))
        else $error("table full reported with free slots");

    // request opcode is known whenever a beat is taken
    a_req_payload_known: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |-> !$isunknown(req.op))
        else $error("request opcode unknown at take");

endmodule

bind linear_probe_hash_map lphm_check u_lphm_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
`default_nettype wire
